>>> rtl/plc_pkg.sv
// Shared types, constants and the encoder decode table for the lid controller.
// No dependencies; used by every rtl file except plc_div through scoped names.
package plc_pkg;

    localparam int RATE_WINDOW_DEF = 8;

    // run state codes
    localparam logic [1:0] MODE_CLOSED = 2'd0;
    localparam logic [1:0] MODE_OPEN   = 2'd1;
    localparam logic [1:0] MODE_COOL   = 2'd2;

    // configuration register indexes
    localparam logic [2:0] REG_LIGHT_MIN  = 3'd0;
    localparam logic [2:0] REG_AVG_HIGH   = 3'd1;
    localparam logic [2:0] REG_SHORTEST   = 3'd2;
    localparam logic [2:0] REG_LONGEST    = 3'd3;
    localparam logic [2:0] REG_COOLDOWN   = 3'd4;
    localparam logic [2:0] REG_STEPS_SYM  = 3'd5;
    localparam logic [2:0] REG_OPEN_ANG   = 3'd6;
    localparam logic [2:0] REG_CLOSE_ANG  = 3'd7;

    // register reset values
    localparam logic [17:0] LIGHT_MIN_RST = 18'd5000;
    localparam logic [7:0]  AVG_HIGH_RST  = 8'd90;
    localparam logic [15:0] SHORTEST_RST  = 16'd400;
    localparam logic [15:0] LONGEST_RST   = 16'd3000;
    localparam logic [31:0] COOLDOWN_RST  = 32'd10000;
    localparam logic [7:0]  STEPS_SYM_RST = 8'd8;
    localparam logic [7:0]  OPEN_ANG_RST  = 8'd0;
    localparam logic [7:0]  CLOSE_ANG_RST = 8'd60;

    // ms per minute, numerator of the bpm quotient
    localparam logic [15:0] BPM_DIVIDEND = 16'd60000;

    // encoder step direction codes
    localparam logic [1:0] ENC_NONE = 2'd0;
    localparam logic [1:0] ENC_UP   = 2'd1;
    localparam logic [1:0] ENC_DOWN = 2'd2;

    typedef struct packed {
        logic load;
        logic enc;
        logic prep;
        logic ring;
        logic mul;
        logic avg;
        logic mode;
        logic out_load;
    } plc_cmd_t;

    typedef struct packed {
        logic div_done;
    } plc_status_t;

    // quadrature decode: {previous pins, current pins} -> direction
    function automatic logic [1:0] enc_dir(input logic [3:0] idx);
        logic [1:0] dir;
        unique case (idx) inside
            4'h1, 4'h7, 4'hE, 4'h8: dir = ENC_UP;
            4'h2, 4'hB, 4'hD, 4'h4: dir = ENC_DOWN;
            default:                dir = ENC_NONE;
        endcase
        return dir;
    endfunction

endpackage

>>> rtl/pulse_triggered_lid_controller_core.sv
// Top level of the pulse-triggered lid controller.
// Depends on plc_pkg, plc_ctrl, plc_dp (which holds two plc_div units).
//
// Each input word is either an encoder pin sample (action 0) or a control pass
// (action 1), and yields exactly one result word carrying the state after it.
// An encoder word is latched, stepped and placed in the output register. A
// control word runs the pulse filter step, then forms the 16-bit bpm quotient
// and the 32-bit symbol quotient in two restoring dividers side by side, the
// symbol divider finishing last, then ring update, averaging multiply, flag
// compare and the run-mode step. One word is in work at a time; in_stall is
// high from acceptance until its result is placed in the output register, and
// a new word is taken while that result still waits for out_stall to drop. The
// beat average is a running ring sum times a reciprocal, so RATE_WINDOW from 2
// to 32 adds no step to the sequence. Config writes are registered and belong
// in idle periods only.
module pulse_triggered_lid_controller_core #(
    parameter int RATE_WINDOW = plc_pkg::RATE_WINDOW_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    // config write port
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    // input word
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        action,
    input  logic        pin_a,
    input  logic        pin_b,
    input  logic        lid_switch_open,
    input  logic [17:0] light_level,
    input  logic        beat_seen,
    input  logic [31:0] time_ms,
    // result word
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  run_state,
    output logic [7:0]  servo_angle,
    output logic        display_on,
    output logic [1:0]  symbol,
    output logic        hr_high,
    output logic [7:0]  beat_average
);

    plc_pkg::plc_cmd_t    cmd;
    plc_pkg::plc_status_t status;

    // sequencer
    plc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .action    (action),
        .out_stall (out_stall),
        .status    (status),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .cmd       (cmd)
    );

    // filter, counters, run mode and result register
    plc_dp #(.RATE_WINDOW(RATE_WINDOW)) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .pin_a           (pin_a),
        .pin_b           (pin_b),
        .lid_switch_open (lid_switch_open),
        .light_level     (light_level),
        .beat_seen       (beat_seen),
        .time_ms         (time_ms),
        .run_state       (run_state),
        .servo_angle     (servo_angle),
        .display_on      (display_on),
        .symbol          (symbol),
        .hr_high         (hr_high),
        .beat_average    (beat_average)
    );

endmodule

>>> rtl/plc_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on nothing; instantiated by plc_dp.
module plc_div #(
    parameter int DVD_W = 32,
    parameter int DSR_W = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DSR_W-1:0] divisor,
    output logic [DVD_W-1:0] quotient,
    output logic [DSR_W-1:0] remainder,
    output logic             done
);

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic [DVD_W-1:0] quo_reg;
    logic [DSR_W-1:0] rem_reg;
    logic [DSR_W-1:0] dsr_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DSR_W:0]   shifted;
    logic [DSR_W:0]   trial;
    logic             fits;
    logic [DSR_W-1:0] rem_next;

    assign shifted  = {rem_reg, quo_reg[DVD_W-1]};
    assign fits     = shifted >= {1'b0, dsr_reg};
    assign trial    = shifted - {1'b0, dsr_reg};
    assign rem_next = fits ? trial[DSR_W-1:0] : shifted[DSR_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (start)
        begin
            cnt_reg <= CNT_W'(DVD_W);
        end
        else if (cnt_reg != '0)
        begin
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end
        else if (cnt_reg != '0)
        begin
            quo_reg <= {quo_reg[DVD_W-2:0], fits};
            rem_reg <= rem_next;
        end
    end

    assign quotient  = quo_reg;
    assign remainder = rem_reg;
    assign done      = (cnt_reg == '0);

endmodule

>>> rtl/plc_dp.sv
// Datapath: config registers, pulse filter, rate ring, encoder counters, run mode.
// Depends on plc_pkg and plc_div; steered by plc_ctrl commands.
module plc_dp #(
    parameter int RATE_WINDOW = plc_pkg::RATE_WINDOW_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  plc_pkg::plc_cmd_t      cmd,
    output plc_pkg::plc_status_t   status,
    input  logic                   cfg_we,
    input  logic [2:0]             cfg_index,
    input  logic [31:0]            cfg_data,
    input  logic                   pin_a,
    input  logic                   pin_b,
    input  logic                   lid_switch_open,
    input  logic [17:0]            light_level,
    input  logic                   beat_seen,
    input  logic [31:0]            time_ms,
    output logic [1:0]             run_state,
    output logic [7:0]             servo_angle,
    output logic                   display_on,
    output logic [1:0]             symbol,
    output logic                   hr_high,
    output logic [7:0]             beat_average
);

    localparam int POS_W     = $clog2(RATE_WINDOW);
    localparam int SUM_W     = $clog2(255 * RATE_WINDOW + 1);
    localparam int SUMX_W    = SUM_W + 1;
    localparam int AVG_SHIFT = 20;
    localparam int MULT_W    = AVG_SHIFT;
    localparam int PROD_W    = SUM_W + MULT_W;
    // ceil(2^20 / window): exact floor division for any ring sum
    localparam logic [MULT_W-1:0] AVG_MULT =
        MULT_W'((2 ** AVG_SHIFT + RATE_WINDOW - 1) / RATE_WINDOW);

    // config
    logic [17:0] light_min_reg;
    logic [7:0]  avg_high_reg;
    logic [15:0] shortest_reg;
    logic [15:0] longest_reg;
    logic [31:0] cooldown_reg;
    logic [7:0]  steps_sym_reg;
    logic [7:0]  open_ang_reg;
    logic [7:0]  close_ang_reg;

    // latched input word
    logic [1:0]  pins_reg;
    logic        lid_reg;
    logic [17:0] level_reg;
    logic        beat_reg;
    logic [31:0] time_reg;

    // block state
    logic [1:0]        mode_reg;
    logic [1:0]        prev_pins_reg;
    logic [31:0]       step_reg;
    logic [31:0]       handled_reg;
    logic [1:0]        symbol_reg;
    logic [7:0]        ring_reg [RATE_WINDOW];
    logic [POS_W-1:0]  pos_reg;
    logic [SUM_W-1:0]  sum_reg;
    logic [31:0]       last_beat_reg;
    logic [7:0]        average_reg;
    logic              high_reg;
    logic [31:0]       cool_start_reg;
    logic              acc_reg;
    logic [PROD_W-1:0] prod_reg;

    // result word
    logic [1:0] run_state_reg;
    logic [7:0] servo_reg;
    logic       display_reg;
    logic [1:0] symbol_out_reg;
    logic       hr_reg;
    logic [7:0] avg_out_reg;

    logic [31:0]      gap;
    logic             level_low;
    logic             beat_ok;
    logic [31:0]      step_diff;
    logic             diff_neg;
    logic [31:0]      diff_mag;
    logic [7:0]       sps_eff;
    logic [15:0]      bpm_q;
    logic             bpm_done;
    logic [31:0]      sym_q;
    logic [7:0]       sym_r;
    logic             sym_done;
    logic [7:0]       bpm_sat;
    logic [SUM_W-1:0] sum_next;
    logic [POS_W-1:0] pos_next;
    logic [7:0]       avg_next;
    logic [31:0]      cool_elapsed;
    logic [1:0]       dir;

    assign gap       = time_reg - last_beat_reg;
    assign level_low = level_reg < light_min_reg;
    assign beat_ok   = (gap != '0) && (gap > {16'd0, shortest_reg})
                       && (gap < {16'd0, longest_reg});

    assign step_diff = step_reg - handled_reg;
    assign diff_neg  = step_diff[31];
    assign diff_mag  = diff_neg ? (~step_diff + 32'd1) : step_diff;
    assign sps_eff   = (steps_sym_reg == '0) ? 8'd1 : steps_sym_reg;

    plc_div #(.DVD_W(16), .DSR_W(16)) u_bpm_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.prep),
        .dividend  (plc_pkg::BPM_DIVIDEND),
        .divisor   (gap[15:0]),
        .quotient  (bpm_q),
        .remainder (),
        .done      (bpm_done)
    );

    plc_div #(.DVD_W(32), .DSR_W(8)) u_sym_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.prep),
        .dividend  (diff_mag),
        .divisor   (sps_eff),
        .quotient  (sym_q),
        .remainder (sym_r),
        .done      (sym_done)
    );

    assign status.div_done = bpm_done & sym_done;

    assign bpm_sat  = (bpm_q[15:8] != '0) ? 8'hFF : bpm_q[7:0];
    assign sum_next = SUM_W'(SUMX_W'(sum_reg) + SUMX_W'(bpm_sat)
                             - SUMX_W'(ring_reg[pos_reg]));
    assign pos_next = (pos_reg == POS_W'(RATE_WINDOW - 1)) ? '0 : pos_reg + 1'b1;
    assign avg_next = prod_reg[AVG_SHIFT +: 8];

    assign cool_elapsed = time_reg - cool_start_reg;
    assign dir          = plc_pkg::enc_dir({prev_pins_reg, pins_reg});

    // config writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            light_min_reg <= plc_pkg::LIGHT_MIN_RST;
            avg_high_reg  <= plc_pkg::AVG_HIGH_RST;
            shortest_reg  <= plc_pkg::SHORTEST_RST;
            longest_reg   <= plc_pkg::LONGEST_RST;
            cooldown_reg  <= plc_pkg::COOLDOWN_RST;
            steps_sym_reg <= plc_pkg::STEPS_SYM_RST;
            open_ang_reg  <= plc_pkg::OPEN_ANG_RST;
            close_ang_reg <= plc_pkg::CLOSE_ANG_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                plc_pkg::REG_LIGHT_MIN: light_min_reg <= cfg_data[17:0];
                plc_pkg::REG_AVG_HIGH:  avg_high_reg  <= cfg_data[7:0];
                plc_pkg::REG_SHORTEST:  shortest_reg  <= cfg_data[15:0];
                plc_pkg::REG_LONGEST:   longest_reg   <= cfg_data[15:0];
                plc_pkg::REG_COOLDOWN:  cooldown_reg  <= cfg_data;
                plc_pkg::REG_STEPS_SYM: steps_sym_reg <= cfg_data[7:0];
                plc_pkg::REG_OPEN_ANG:  open_ang_reg  <= cfg_data[7:0];
                plc_pkg::REG_CLOSE_ANG: close_ang_reg <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // input word capture and result word
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            pins_reg  <= {pin_a, pin_b};
            lid_reg   <= lid_switch_open;
            level_reg <= light_level;
            beat_reg  <= beat_seen;
            time_reg  <= time_ms;
        end
        if (cmd.mul)
        begin
            prod_reg <= PROD_W'(sum_reg) * PROD_W'(AVG_MULT);
        end
        if (cmd.out_load)
        begin
            run_state_reg  <= mode_reg;
            servo_reg      <= (mode_reg == plc_pkg::MODE_OPEN) ? open_ang_reg
                                                               : close_ang_reg;
            display_reg    <= (mode_reg == plc_pkg::MODE_OPEN);
            symbol_out_reg <= symbol_reg;
            hr_reg         <= high_reg;
            avg_out_reg    <= average_reg;
        end
    end

    // block state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= plc_pkg::MODE_CLOSED;
            prev_pins_reg  <= '0;
            step_reg       <= '0;
            handled_reg    <= '0;
            symbol_reg     <= '0;
            for (int i = 0; i < RATE_WINDOW; i++)
            begin
                ring_reg[i] <= '0;
            end
            pos_reg        <= '0;
            sum_reg        <= '0;
            last_beat_reg  <= '0;
            average_reg    <= '0;
            high_reg       <= 1'b0;
            cool_start_reg <= '0;
            acc_reg        <= 1'b0;
        end
        else
        begin
            if (cmd.enc)
            begin
                if (mode_reg == plc_pkg::MODE_OPEN)
                begin
                    if (dir == plc_pkg::ENC_UP)
                    begin
                        step_reg <= step_reg + 32'd1;
                    end
                    else if (dir == plc_pkg::ENC_DOWN)
                    begin
                        step_reg <= step_reg - 32'd1;
                    end
                end
                prev_pins_reg <= pins_reg;
            end

            if (cmd.prep)
            begin
                acc_reg <= !level_low && beat_reg && beat_ok;
                if (level_low)
                begin
                    high_reg <= 1'b0;
                end
                else if (beat_reg)
                begin
                    last_beat_reg <= time_reg;
                end
            end

            if (cmd.ring && acc_reg)
            begin
                ring_reg[pos_reg] <= bpm_sat;
                sum_reg           <= sum_next;
                pos_reg           <= pos_next;
            end

            if (cmd.avg && acc_reg)
            begin
                average_reg <= avg_next;
                high_reg    <= avg_next > avg_high_reg;
            end

            if (cmd.mode)
            begin
                case (mode_reg)
                    plc_pkg::MODE_CLOSED:
                    begin
                        if (high_reg)
                        begin
                            step_reg    <= '0;
                            handled_reg <= '0;
                            mode_reg    <= plc_pkg::MODE_OPEN;
                        end
                    end
                    plc_pkg::MODE_OPEN:
                    begin
                        if (!lid_reg)
                        begin
                            for (int i = 0; i < RATE_WINDOW; i++)
                            begin
                                ring_reg[i] <= '0;
                            end
                            pos_reg        <= '0;
                            sum_reg        <= '0;
                            high_reg       <= 1'b0;
                            cool_start_reg <= time_reg;
                            mode_reg       <= plc_pkg::MODE_COOL;
                        end
                        else
                        begin
                            // whole symbol moves; the remainder stays pending
                            if (diff_neg)
                            begin
                                handled_reg <= step_reg + {24'd0, sym_r};
                                symbol_reg  <= symbol_reg - sym_q[1:0];
                            end
                            else
                            begin
                                handled_reg <= step_reg - {24'd0, sym_r};
                                symbol_reg  <= symbol_reg + sym_q[1:0];
                            end
                        end
                    end
                    default:
                    begin
                        if (cool_elapsed >= cooldown_reg)
                        begin
                            mode_reg <= plc_pkg::MODE_CLOSED;
                        end
                    end
                endcase
            end
        end
    end

    assign run_state    = run_state_reg;
    assign servo_angle  = servo_reg;
    assign display_on   = display_reg;
    assign symbol       = symbol_out_reg;
    assign hr_high      = hr_reg;
    assign beat_average = avg_out_reg;

endmodule

>>> rtl/plc_ctrl.sv
// Sequencer: input/output handshake and the step order of one word.
// Depends on plc_pkg; drives plc_dp through command and status structs.
module plc_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 action,
    input  logic                 out_stall,
    input  plc_pkg::plc_status_t status,
    output logic                 in_stall,
    output logic                 out_valid,
    output plc_pkg::plc_cmd_t    cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_ENC,
        S_PREP,
        S_DIV,
        S_RING,
        S_MUL,
        S_AVG,
        S_MODE,
        S_OUT
    } state_t;

    state_t state_reg;
    logic   out_valid_reg;
    logic   accept;
    logic   out_free;

    assign accept   = in_valid && (state_reg == S_IDLE);
    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        cmd          = '0;
        cmd.load     = accept;
        cmd.enc      = (state_reg == S_ENC);
        cmd.prep     = (state_reg == S_PREP);
        cmd.ring     = (state_reg == S_RING);
        cmd.mul      = (state_reg == S_MUL);
        cmd.avg      = (state_reg == S_AVG);
        cmd.mode     = (state_reg == S_MODE);
        cmd.out_load = (state_reg == S_OUT) && out_free;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        state_reg <= action ? S_PREP : S_ENC;
                    end
                end
                S_ENC:  state_reg <= S_OUT;
                S_PREP: state_reg <= S_DIV;
                S_DIV:
                begin
                    if (status.div_done)
                    begin
                        state_reg <= S_RING;
                    end
                end
                S_RING: state_reg <= S_MUL;
                S_MUL:  state_reg <= S_AVG;
                S_AVG:  state_reg <= S_MODE;
                S_MODE: state_reg <= S_OUT;
                S_OUT:
                begin
                    if (out_free)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

>>> rtl/plc_chk.sv
// Port-level checks for the lid controller, bound to the top level.
// Depends on plc_pkg and pulse_triggered_lid_controller_core.
module plc_chk (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic       out_valid,
    input logic       out_stall,
    input logic [1:0] run_state,
    input logic       display_on
);

    // one word in work at a time
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input taken while a word is in work");

    a_state_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (run_state == plc_pkg::MODE_CLOSED
                       || run_state == plc_pkg::MODE_OPEN
                       || run_state == plc_pkg::MODE_COOL))
        else $error("run_state code out of range");

    a_display: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (display_on == (run_state == plc_pkg::MODE_OPEN)))
        else $error("display_on disagrees with run_state");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(run_state)))
        else $error("stalled result changed");

endmodule

bind pulse_triggered_lid_controller_core plc_chk u_plc_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .run_state  (run_state),
    .display_on (display_on)
);

>>> bench/pulse_triggered_lid_controller_core_test.sv
// Testbench for pulse_triggered_lid_controller_core: a bit-true predictor of the
// lid controller feeds a result scoreboard. Depends on plc_pkg and the rtl files.
module pulse_triggered_lid_controller_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int  WINDOW      = plc_pkg::RATE_WINDOW_DEF;
    localparam int  CYCLE_LIMIT = 1500000;
    localparam bit  ACT_ENC     = 1'b0;
    localparam bit  ACT_CTRL    = 1'b1;

    typedef struct packed {
        logic [1:0] run_state;
        logic [7:0] servo_angle;
        logic       display_on;
        logic [1:0] symbol;
        logic       hr_high;
        logic [7:0] beat_average;
    } lid_status_t;

    // Result queue: notes the predicted status of each accepted word and
    // compares every result word with the oldest one.
    class lid_scoreboard;
        lid_status_t pending[$];
        int          mismatches;

        function void note_word(lid_status_t s);
            pending.push_back(s);
        endfunction

        function void check_word(lid_status_t got);
            lid_status_t want;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result word %h", got);
                return;
            end
            want = pending.pop_front();
            if (got !== want)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"mismatch: want st=%0d ang=%0d disp=%0d sym=%0d hi=%0d avg=%0d,",
                              " got st=%0d ang=%0d disp=%0d sym=%0d hi=%0d avg=%0d"},
                             want.run_state, want.servo_angle, want.display_on,
                             want.symbol, want.hr_high, want.beat_average,
                             got.run_state, got.servo_angle, got.display_on,
                             got.symbol, got.hr_high, got.beat_average);
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [2:0] cfg_index = plc_pkg::REG_LIGHT_MIN;
    logic [31:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic action = 1'b0, pin_a = 1'b0, pin_b = 1'b0, lid_switch_open = 1'b0;
    logic [17:0] light_level = '0;
    logic beat_seen = 1'b0;
    logic [31:0] time_ms = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [1:0] run_state;
    logic [7:0] servo_angle;
    logic display_on;
    logic [1:0] symbol;
    logic hr_high;
    logic [7:0] beat_average;

    always #6 clk = ~clk;

    pulse_triggered_lid_controller_core dut (.*);

    // ---- predictor state: configuration copy and block state ----
    logic [17:0] light_min;
    logic [7:0]  avg_high;
    logic [15:0] shortest, longest;
    logic [31:0] cooldown_len;
    logic [7:0]  steps_sym, open_ang, close_ang;
    logic [1:0]  mode;
    logic [1:0]  last_pins;
    logic [31:0] steps, steps_done;
    logic [1:0]  sym;
    logic [7:0]  rates[WINDOW];
    int          rate_pos;
    logic [31:0] prev_beat;
    logic [7:0]  avg;
    logic        high;
    logic [31:0] cool_start;

    lid_scoreboard board = new();
    int  cycles = 0;
    bit  quiet_sender = 0, quiet_receiver = 0;
    bit  held = 0;
    logic [31:0] clock_ms = 0;  // running time used by control words

    // register writes track into the predictor copy
    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            plc_pkg::REG_LIGHT_MIN: light_min    = val[17:0];
            plc_pkg::REG_AVG_HIGH:  avg_high     = val[7:0];
            plc_pkg::REG_SHORTEST:  shortest     = val[15:0];
            plc_pkg::REG_LONGEST:   longest      = val[15:0];
            plc_pkg::REG_COOLDOWN:  cooldown_len = val;
            plc_pkg::REG_STEPS_SYM: steps_sym    = val[7:0];
            plc_pkg::REG_OPEN_ANG:  open_ang     = val[7:0];
            default:                close_ang    = val[7:0];
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // bpm filter: weak light clears the flag, accepted intervals feed the ring
    function automatic void filter_beat(logic [17:0] lvl, logic beat, logic [31:0] now);
        logic [31:0] gap, bpm, sum;
        if (lvl < light_min)
        begin
            high = 1'b0;
            return;
        end
        if (!beat)
            return;
        gap = now - prev_beat;
        prev_beat = now;
        if (gap == 0 || gap <= shortest || gap >= longest)
            return;
        bpm = 32'd60000 / gap;
        if (bpm > 255)
            bpm = 255;
        rates[rate_pos] = bpm[7:0];
        rate_pos = (rate_pos + 1) % WINDOW;
        sum = 0;
        foreach (rates[i])
            sum += rates[i];
        avg = 8'(sum / WINDOW);
        high = avg > avg_high;
    endfunction

    // symbol moves by whole groups of steps; counter difference is signed
    function automatic void advance_symbol();
        longint per, diff, n;
        per  = (steps_sym == 0) ? 1 : steps_sym;
        diff = longint'($signed(steps - steps_done));
        if (diff >= per)
        begin
            n = diff / per;
            sym = sym + 2'(n);
            steps_done = steps_done + 32'(n * per);
        end
        else if (diff <= -per)
        begin
            n = (-diff) / per;
            sym = sym - 2'(n);
            steps_done = steps_done - 32'(n * per);
        end
    endfunction

    function automatic lid_status_t predict_status(logic act, logic a, logic b, logic lid,
                                                   logic [17:0] lvl, logic beat,
                                                   logic [31:0] now);
        lid_status_t s;
        logic [1:0] dir;
        if (act == ACT_CTRL)
        begin
            filter_beat(lvl, beat, now);
            case (mode)
                plc_pkg::MODE_CLOSED:
                    if (high)
                    begin
                        steps = 0;
                        steps_done = 0;
                        mode = plc_pkg::MODE_OPEN;
                    end
                plc_pkg::MODE_OPEN:
                    if (!lid)
                    begin
                        foreach (rates[i])
                            rates[i] = 0;
                        rate_pos = 0;
                        high = 1'b0;
                        cool_start = now;
                        mode = plc_pkg::MODE_COOL;
                    end
                    else
                        advance_symbol();
                default:
                    if (now - cool_start >= cooldown_len)
                        mode = plc_pkg::MODE_CLOSED;
            endcase
        end
        else
        begin
            // same decode as the quadrature table: up 1,7,E,8 down 2,B,D,4
            case ({last_pins, a, b})
                4'h1, 4'h7, 4'hE, 4'h8: dir = plc_pkg::ENC_UP;
                4'h2, 4'hB, 4'hD, 4'h4: dir = plc_pkg::ENC_DOWN;
                default:                dir = plc_pkg::ENC_NONE;
            endcase
            if (mode == plc_pkg::MODE_OPEN)
            begin
                if (dir == plc_pkg::ENC_UP)
                    steps = steps + 1;
                else if (dir == plc_pkg::ENC_DOWN)
                    steps = steps - 1;
            end
            last_pins = {a, b};
        end
        s.run_state    = mode;
        s.servo_angle  = (mode == plc_pkg::MODE_OPEN) ? open_ang : close_ang;
        s.display_on   = mode == plc_pkg::MODE_OPEN;
        s.symbol       = sym;
        s.hr_high      = high;
        s.beat_average = avg;
        return s;
    endfunction

    // drive one word; the predictor runs at the accepting edge and valid
    // stays up so the next word can follow with no gap
    task automatic send_word(logic act, logic a, logic b, logic lid,
                             logic [17:0] lvl, logic beat, logic [31:0] now);
        if (!quiet_sender && $urandom_range(99) < 8)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
            while (!quiet_sender && $urandom_range(99) < 8)
                @(posedge clk);
        end
        in_valid <= 1'b1;
        action <= act; pin_a <= a; pin_b <= b; lid_switch_open <= lid;
        light_level <= lvl; beat_seen <= beat; time_ms <= now;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        board.note_word(predict_status(act, a, b, lid, lvl, beat, now));
    endtask

    task automatic send_enc(logic a, logic b);
        send_word(ACT_ENC, a, b, 1'($urandom), 18'($urandom), 1'($urandom), $urandom);
    endtask

    task automatic send_ctrl(logic lid, logic [17:0] lvl, logic beat, logic [31:0] dt);
        clock_ms += dt;
        send_word(ACT_CTRL, 1'($urandom), 1'($urandom), lid, lvl, beat, clock_ms);
    endtask

    // wait for every expected result plus the control-word latency
    task automatic drain();
        in_valid <= 1'b0;
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    // one well-formed session: beats open the lid, encoder turns, lid closes
    task automatic lid_session(int beats);
        logic [1:0] gray[4] = '{2'b00, 2'b01, 2'b11, 2'b10};
        int ph = 0;
        int turns;
        repeat (beats)
            send_ctrl(1, 18'($urandom_range(262143, 6000)), 1,
                      $urandom_range(450, 900));
        turns = $urandom_range(4, 30);
        repeat (turns)
        begin
            if ($urandom_range(9) < 7)
                ph = (ph + 1) % 4;
            else if ($urandom_range(1))
                ph = (ph + 3) % 4;
            else
                ph = (ph + 2) % 4;          // illegal double jump
            send_enc(gray[ph][1], gray[ph][0]);
            if ($urandom_range(4) == 0)
                send_ctrl(1, 18'($urandom), 1'($urandom), $urandom_range(1, 50));
        end
        send_ctrl($urandom_range(3) == 0, 18'($urandom), 1'($urandom),
                  $urandom_range(1, 100));
        send_ctrl(0, 18'($urandom), 0, $urandom_range(1, 100));
        repeat ($urandom_range(1, 4))
            send_ctrl(1'($urandom), 18'($urandom), 1'($urandom), $urandom_range(0, 6000));
    endtask

    // receiver: stalls at random, checks each accepted result
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
                board.check_word({run_state, servo_angle, display_on,
                                  symbol, hr_high, beat_average});
            out_stall <= !quiet_receiver && ($urandom_range(99) < 8);
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin
        light_min = plc_pkg::LIGHT_MIN_RST; avg_high = plc_pkg::AVG_HIGH_RST;
        shortest = plc_pkg::SHORTEST_RST; longest = plc_pkg::LONGEST_RST;
        cooldown_len = plc_pkg::COOLDOWN_RST; steps_sym = plc_pkg::STEPS_SYM_RST;
        open_ang = plc_pkg::OPEN_ANG_RST; close_ang = plc_pkg::CLOSE_ANG_RST;
        mode = plc_pkg::MODE_CLOSED; last_pins = 0; steps = 0; steps_done = 0; sym = 0;
        foreach (rates[i])
            rates[i] = 0;
        rate_pos = 0; prev_beat = 0; avg = 0; high = 0; cool_start = 0;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---- directed: field extremes and special cases at reset settings ----
        send_enc(1, 1);                            // closed: pins tracked only
        send_ctrl(1, 18'h3FFFF, 1, 32'hFFFF_FF00); // far beat, rejected gap
        send_ctrl(1, 18'h3FFFF, 1, 0);             // zero interval
        send_ctrl(1, 18'd4999, 1, 500);            // weak light
        send_word(ACT_CTRL, 1, 1, 1, 18'h3FFFF, 1, 32'hFFFF_FFFF); // time wraps
        clock_ms = 32'hFFFF_FFFF;
        send_ctrl(1, 18'd5000, 1, 400);            // on the short bound
        send_ctrl(1, 18'd5000, 1, 2999);           // just inside long bound
        drain();
        write_reg(plc_pkg::REG_SHORTEST, 0);
        write_reg(plc_pkg::REG_LONGEST, 16'hFFFF);
        write_reg(plc_pkg::REG_AVG_HIGH, 0);
        write_reg(plc_pkg::REG_STEPS_SYM, 0);      // acts as one
        write_reg(plc_pkg::REG_OPEN_ANG, 180);
        write_reg(plc_pkg::REG_CLOSE_ANG, 0);
        write_reg(plc_pkg::REG_COOLDOWN, 0);
        write_reg(plc_pkg::REG_LIGHT_MIN, 0);
        send_ctrl(1, 0, 1, 1);                     // bpm saturates, opens
        send_enc(0, 0); send_enc(0, 1); send_enc(1, 1); send_enc(0, 0);
        send_enc(1, 0); send_enc(0, 0);
        send_ctrl(1, 0, 0, 3);
        send_ctrl(0, 0, 0, 3);                     // close into cooldown
        send_enc(1, 0);                            // not open: no step
        send_ctrl(1, 0, 0, 0);                     // zero cooldown ends
        drain();

        // ---- random phases, several settings ----
        for (int phase = 0; phase < 6; phase++)
        begin
            quiet_sender   = (phase == 2);
            quiet_receiver = (phase == 2);
            write_reg(plc_pkg::REG_LIGHT_MIN,
                      phase == 5 ? 18'h3FFFF : $urandom_range(0, 8000));
            write_reg(plc_pkg::REG_AVG_HIGH, phase == 4 ? 255 : $urandom_range(0, 120));
            write_reg(plc_pkg::REG_SHORTEST,
                      phase == 4 ? 16'hFFFF : $urandom_range(200, 440));
            write_reg(plc_pkg::REG_LONGEST, phase == 3 ? 1 : $urandom_range(1000, 65535));
            write_reg(plc_pkg::REG_COOLDOWN,
                      phase == 5 ? 32'hFFFF_FFFF : $urandom_range(0, 3000));
            write_reg(plc_pkg::REG_STEPS_SYM, phase == 1 ? 255 : $urandom_range(1, 6));
            write_reg(plc_pkg::REG_OPEN_ANG, $urandom_range(0, 180));
            write_reg(plc_pkg::REG_CLOSE_ANG, $urandom_range(0, 180));
            for (int k = 0; k < 125; )
            begin
                if ($urandom_range(9) < 7)
                begin
                    lid_session($urandom_range(1, 10));
                    k += 30;
                end
                else
                begin
                    if ($urandom_range(1))
                        send_enc(1'($urandom), 1'($urandom));
                    else
                        send_word(ACT_CTRL, 1'($urandom), 1'($urandom), 1'($urandom),
                                  18'($urandom), 1'($urandom), $urandom);
                    k++;
                end
                if (phase == 3 && k >= 60 && !held)
                begin
                    // hold off until every result is back
                    held = 1;
                    in_valid <= 1'b0;
                    @(posedge clk);
                    while (board.pending.size() != 0)
                        @(posedge clk);
                end
            end
            drain();
        end

        quiet_sender = 0;
        drain();
        if (board.mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
